/* hw/rtl/rcd_pkg.sv */
// Shared types, codes and defaults for the reversible circular deque.
package rcd_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_READ       = 3'd4,
    ACT_WRITE      = 3'd5,
    ACT_REVERSE    = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

/* hw/rtl/rcd_ctrl.sv */
// Controller state machine: sequences capture, execute and result hold.
module rcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rcd_pkg::cmd_t cmd
);
  import rcd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) state_next = in_valid ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = !((state == S_IDLE) || ((state == S_HOLD) && !out_stall));
    out_valid   = (state == S_HOLD);
    cmd.capture = in_valid && !in_stall;
    cmd.execute = (state == S_EXEC);
  end

`ifndef NO_ASSERTIONS
  a_exec_to_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_HOLD))
    else $error("execute not followed by result hold");

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("captured item not executed");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");
`endif

endmodule

/* hw/rtl/rcd_datapath.sv */
// Datapath: ring store, head/tail pointers, count, direction and result registers.
module rcd_datapath #(
  parameter int CAPACITY   = rcd_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = rcd_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rcd_pkg::cmd_t                cmd,
  input  logic [rcd_pkg::ACTION_W-1:0] action,
  input  logic [rcd_pkg::POS_W-1:0]    position,
  input  logic [rcd_pkg::VALUE_W-1:0]  item_value,
  output logic [rcd_pkg::VALUE_W-1:0]  read_value,
  output logic [rcd_pkg::COUNT_W-1:0]  item_count,
  output logic [rcd_pkg::STATUS_W-1:0] status
);
  import rcd_pkg::*;

  localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [SW:0]   CAP_S = (SW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // captured item
  action_t              act_q;
  logic [POS_W-1:0]     pos_q;
  logic [VALUE_W-1:0]   val_q;

  // deque state
  logic [SW-1:0]        head;
  logic [SW-1:0]        tail;
  logic [CW-1:0]        occ;
  logic                 rev;
  logic [SW-1:0]        head_next;
  logic [SW-1:0]        tail_next;
  logic [CW-1:0]        occ_next;
  logic                 rev_next;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;

  // result registers
  logic                 rd_ok_q;
  logic [COUNT_W-1:0]   count_q;
  status_t              status_q;
  status_t              status_next;
  logic                 rd_ok;
  logic                 we;

  logic [SW-1:0]        offset;
  logic                 back_step;
  logic [SW:0]          fwd;
  logic [SW:0]          bwd;
  logic [SW-1:0]        slot;
  logic                 full;
  logic                 empty;
  logic                 in_range;
  logic [63:0]          val_wide;
  logic [63:0]          rd_wide;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action_t'(action);
      pos_q <= position;
      val_q <= item_value;
    end
  end

  assign full     = (occ == CAP_C);
  assign empty    = (occ == '0);
  assign in_range = CMPW'(pos_q) < CMPW'(occ);

  always_comb begin
    offset    = SW'(pos_q);
    back_step = 1'b0;
    unique case (act_q)
      ACT_PUSH_BACK:  offset = SW'(occ);
      ACT_PUSH_FRONT: begin
        offset    = SW'(1);
        back_step = 1'b1;
      end
      ACT_POP_BACK:   offset = SW'(occ - CW'(2));
      ACT_POP_FRONT:  offset = SW'(1);
      default:        offset = SW'(pos_q);
    endcase
  end

  // ring step: both sums stay below twice the capacity
  always_comb begin
    fwd = {1'b0, head} + {1'b0, offset};
    if (fwd >= CAP_S) fwd = fwd - CAP_S;
    bwd = {1'b0, head} + CAP_S - {1'b0, offset};
    if (bwd >= CAP_S) bwd = bwd - CAP_S;
    slot = (rev ^ back_step) ? bwd[SW-1:0] : fwd[SW-1:0];
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    occ_next    = occ;
    rev_next    = rev;
    status_next = ST_OK;
    we          = 1'b0;
    rd_ok       = 1'b0;
    unique case (act_q)
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we        = 1'b1;
          tail_next = slot;
          if (empty) head_next = slot;
          occ_next  = occ + CW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          we        = 1'b1;
          head_next = slot;
          if (empty) tail_next = slot;
          occ_next  = occ + CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          if (occ > CW'(1)) tail_next = slot;
          occ_next = occ - CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          if (occ > CW'(1)) head_next = slot;
          occ_next = occ - CW'(1);
        end
      end
      ACT_READ: begin
        if (!in_range) status_next = ST_RANGE;
        else rd_ok = 1'b1;
      end
      ACT_WRITE: begin
        if (!in_range) status_next = ST_RANGE;
        else we = 1'b1;
      end
      ACT_REVERSE: begin
        head_next = tail;
        tail_next = head;
        rev_next  = !rev;
      end
      ACT_CLEAR: begin
        head_next = '0;
        tail_next = '0;
        occ_next  = '0;
        rev_next  = 1'b0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
      rev  <= 1'b0;
    end else if (cmd.execute) begin
      head <= head_next;
      tail <= tail_next;
      occ  <= occ_next;
      rev  <= rev_next;
    end
  end

  assign val_wide = 64'(val_q);

  always_ff @(posedge clk) begin
    if (cmd.execute && we) begin
      mem[slot] <= val_wide[DATA_WIDTH-1:0];
    end
    if (cmd.execute) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rd_ok_q  <= rd_ok;
      count_q  <= COUNT_W'(occ_next);
      status_q <= status_next;
    end
  end

  assign rd_wide    = 64'(rd_q);
  assign read_value = rd_ok_q ? rd_wide[VALUE_W-1:0] : '0;
  assign item_count = count_q;
  assign status     = status_q;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CAP_C)
    else $error("occupancy above capacity");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && (status_next == ST_FULL)) |=> ($stable(occ) && $stable(head)
      && $stable(tail)))
    else $error("refused push changed state");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && ((act_q == ACT_POP_BACK) || (act_q == ACT_POP_FRONT)) && !empty)
      |=> (occ == $past(occ) - CW'(1)))
    else $error("pop did not decrement occupancy");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> !(rd_ok_q && (status_q != ST_OK)))
    else $error("read data returned with error status");
`endif

endmodule

/* hw/rtl/reversible_circular_deque.sv */
// Reversible circular deque: push/pop at both ends, indexed read/write, O(1) reverse and
// clear over a ring of CAPACITY elements. One result per transfer in. Each item passes through the
// execute state (pointer update, ring store write or registered read) and is then held in
// the result registers until transferred out; a new item is taken in the cycle its
// predecessor's result leaves, so items do not overlap: the input is stalled while an item
// executes and while its result is held by out_stall. No clearing pass after reset.
module reversible_circular_deque #(
  parameter int CAPACITY   = rcd_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = rcd_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rcd_pkg::ACTION_W-1:0] action,
  input  logic [rcd_pkg::POS_W-1:0]    position,
  input  logic [rcd_pkg::VALUE_W-1:0]  item_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcd_pkg::VALUE_W-1:0]  read_value,
  output logic [rcd_pkg::COUNT_W-1:0]  item_count,
  output logic [rcd_pkg::STATUS_W-1:0] status
);
  import rcd_pkg::*;

  cmd_t cmd;

  rcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rcd_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .action     (action),
    .position   (position),
    .item_value (item_value),
    .read_value (read_value),
    .item_count (item_count),
    .status     (status)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the reversible circular deque.
module tb;
  import rcd_pkg::*;

  localparam int DEPTH = DEF_CAPACITY;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] item_count;
    status_t            status;
  } deque_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_t             action = ACT_READ;
  logic [POS_W-1:0]    position = '0;
  logic [VALUE_W-1:0]  item_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VALUE_W-1:0]  read_value;
  logic [COUNT_W-1:0]  item_count;
  logic [STATUS_W-1:0] status;

  // predicted deque state
  logic [VALUE_W-1:0]  ring_store [DEPTH];
  logic [POS_W-1:0]    ring_head = '0;
  logic [POS_W-1:0]    ring_tail = '0;
  logic [COUNT_W-1:0]  ring_count = '0;
  logic                ring_reversed = 1'b0;

  deque_result_t       expected_results [$];
  deque_result_t       oldest;
  int                  errors = 0;
  bit                  in_gaps_on = 1'b1;
  bit                  out_gaps_on = 1'b1;
  int                  hold_req = 0;
  int                  stall_left = 0;
  int                  stall_pick;

  reversible_circular_deque uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .position  (position),
    .item_value(item_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_value(read_value),
    .item_count(item_count),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("reversible_circular_deque: mismatch");
    $finish;
  end

  // slot lying the given number of steps from the head, along the walk or against it
  function automatic logic [POS_W-1:0] ring_slot(logic [POS_W-1:0] steps, bit against);
    if (ring_reversed ^ against) return ring_head - steps;
    return ring_head + steps;
  endfunction

  function automatic deque_result_t apply_deque_op(action_t a, logic [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] v);
    deque_result_t    res;
    logic [POS_W-1:0] s;
    logic [COUNT_W-1:0] back_dist;
    res.read_value = '0;
    res.status     = ST_OK;
    case (a)
      ACT_PUSH_BACK: begin
        if (ring_count == DEPTH) res.status = ST_FULL;
        else begin
          s = ring_slot(ring_count[POS_W-1:0], 1'b0);
          ring_store[s] = v;
          if (ring_count == 0) ring_head = s;
          ring_tail = s;
          ring_count++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (ring_count == DEPTH) res.status = ST_FULL;
        else begin
          s = ring_slot(POS_W'(1), 1'b1);
          ring_store[s] = v;
          if (ring_count == 0) ring_tail = s;
          ring_head = s;
          ring_count++;
        end
      end
      ACT_POP_BACK: begin
        if (ring_count == 0) res.status = ST_EMPTY;
        else begin
          back_dist = ring_count - COUNT_W'(2);
          if (ring_count > 1) ring_tail = ring_slot(back_dist[POS_W-1:0], 1'b0);
          ring_count--;
        end
      end
      ACT_POP_FRONT: begin
        if (ring_count == 0) res.status = ST_EMPTY;
        else begin
          if (ring_count > 1) ring_head = ring_slot(POS_W'(1), 1'b0);
          ring_count--;
        end
      end
      ACT_READ: begin
        if (pos >= ring_count) res.status = ST_RANGE;
        else res.read_value = ring_store[ring_slot(pos, 1'b0)];
      end
      ACT_WRITE: begin
        if (pos >= ring_count) res.status = ST_RANGE;
        else ring_store[ring_slot(pos, 1'b0)] = v;
      end
      ACT_REVERSE: begin
        s = ring_head;
        ring_head = ring_tail;
        ring_tail = s;
        ring_reversed = !ring_reversed;
      end
      default: begin
        ring_head = '0;
        ring_tail = '0;
        ring_count = '0;
        ring_reversed = 1'b0;
      end
    endcase
    res.item_count = ring_count;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!in_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: compare each transfer out with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h/%0d/%0d",
                 $time, read_value, item_count, status);
        errors++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("read_value", oldest.read_value, read_value);
        check_field("item_count", VALUE_W'(oldest.item_count), VALUE_W'(item_count));
        check_field("status", VALUE_W'(oldest.status), VALUE_W'(status));
      end
    end
  end

  // result side stall: random short and long stretches, or a requested long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req <= 0;
      end else if (stall_left == 0 && out_gaps_on) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick >= 60)
          stall_left = (stall_pick < 92) ? $urandom_range(1, 3) :
                       (stall_pick < 99) ? $urandom_range(4, 12) : $urandom_range(20, 60);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_op(action_t a, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] v);
    int gap;
    in_valid   <= 1'b1;
    action     <= a;
    position   <= pos;
    item_value <= v;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_deque_op(a, pos, v));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_deque();
    send_op(ACT_POP_BACK, 4'd0, '0);
    send_op(ACT_POP_FRONT, 4'd15, '1);
    send_op(ACT_READ, 4'd0, '0);
    send_op(ACT_WRITE, 4'd0, 32'h5a5a_a5a5);
    send_op(ACT_REVERSE, 4'd0, '0);
    send_op(ACT_PUSH_FRONT, 4'd0, '1);
    send_op(ACT_REVERSE, 4'd0, '0);
    send_op(ACT_READ, 4'd0, '0);
    send_op(ACT_POP_BACK, 4'd0, '0);
  endtask

  task automatic test_full_deque();
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      v = (i == 0) ? '1 : (i == 1) ? '0 : $urandom;
      send_op((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, POS_W'(i), v);
    end
    send_op(ACT_PUSH_BACK, 4'd0, 32'h1234_5678);
    send_op(ACT_READ, 4'd15, '0);
    send_op(ACT_WRITE, 4'd0, '1);
    send_op(ACT_REVERSE, 4'd0, '0);
    send_op(ACT_CLEAR, 4'd0, '0);
  endtask

  // hold the result side off for a long stretch while transfers keep being offered
  task automatic test_backpressure();
    wait_results_drained();
    in_gaps_on = 1'b0;
    hold_req <= 300;
    for (int i = 0; i < 30; i++)
      send_op((i < 20) ? ACT_PUSH_BACK : ACT_READ, POS_W'($urandom_range(0, 15)), $urandom);
    in_gaps_on = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_ops(int n_items);
    int                 r;
    int                 push_pct;
    int                 pop_pct;
    action_t            a;
    logic [POS_W-1:0]   p;
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_pct = 55; pop_pct = 15; end
          1: begin push_pct = 20; pop_pct = 45; end
          default: begin push_pct = 35; pop_pct = 30; end
        endcase
        in_gaps_on  = ($urandom_range(0, 3) != 0);
        out_gaps_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) a = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else if (r < push_pct + pop_pct) a = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
      else begin
        r = $urandom_range(0, 99);
        a = (r < 50) ? ACT_READ : (r < 80) ? ACT_WRITE : (r < 95) ? ACT_REVERSE : ACT_CLEAR;
      end
      if (ring_count != 0 && $urandom_range(0, 9) < 8)
        p = POS_W'($urandom_range(0, ring_count - 1));
      else
        p = POS_W'($urandom_range(0, 15));
      r = $urandom_range(0, 19);
      v = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
      send_op(a, p, v);
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_deque();
    test_full_deque();
    test_backpressure();
    test_random_ops(1850);
    wait_results_drained();
    if (errors == 0) $display("reversible_circular_deque: match");
    else $display("reversible_circular_deque: mismatch");
    $finish;
  end

endmodule

/* reversible_circular_deque.f */
hw/rtl/rcd_pkg.sv
hw/rtl/rcd_ctrl.sv
hw/rtl/rcd_datapath.sv
hw/rtl/reversible_circular_deque.sv
tb/tb.sv
